>>> hw/rtl/sbrm_pkg.sv
// Shared types and constants for the serial bank register mapper.
// Holds the beat structs, status codes and register indexes; no dependencies.
package sbrm_pkg;

	// Width of the processor cycle stamp
	localparam int unsigned STAMP_W = 40;

	// Configuration register indexes
	localparam logic [1:0] CFG_WRAM_SIZE      = 2'd0;
	localparam logic [1:0] CFG_IGNORE_WRAM_EN = 2'd1;
	localparam logic [1:0] CFG_NO_MIRROR      = 2'd2;

	// Write status codes
	localparam logic [1:0] ST_TOO_SOON = 2'd0;
	localparam logic [1:0] ST_RESET    = 2'd1;
	localparam logic [1:0] ST_SHIFTED  = 2'd2;
	localparam logic [1:0] ST_LOADED   = 2'd3;

	// Internal register targets
	localparam logic [1:0] SEL_CONTROL  = 2'd0;
	localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
	localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
	localparam logic [1:0] SEL_PRG      = 2'd3;

	// Program bank modes (control bits 3:2)
	localparam logic [1:0] PRG_FIX_HIGH = 2'd3;
	localparam logic [1:0] PRG_FIX_LOW  = 2'd2;

	// Work RAM sizes
	localparam logic [1:0] WRAM_NONE = 2'd0;
	localparam logic [1:0] WRAM_16K  = 2'd2;
	localparam logic [1:0] WRAM_32K  = 2'd3;

	// Reset values
	localparam logic [4:0] CONTROL_RST   = 5'd15;
	localparam logic [1:0] WRAM_SIZE_RST = 2'd1;
	localparam logic [2:0] SHIFT_LAST    = 3'd4;

	typedef struct packed {
		logic [1:0]         reg_select;
		logic [7:0]         write_data;
		logic [STAMP_W-1:0] cycle_stamp;
	} wr_beat_t;

	typedef struct packed {
		logic [1:0] write_status;
		logic [4:0] prg_bank_low;
		logic [4:0] prg_bank_high;
		logic [4:0] chr_bank_low;
		logic [4:0] chr_bank_high;
		logic [1:0] mirroring;
		logic       mirror_driven;
		logic       wram_enabled;
		logic [1:0] wram_bank;
	} res_beat_t;

endpackage

>>> hw/rtl/serial_bank_register_mapper.sv
// Top level of the serial bank register mapper: write beats in, bank state out.
// Depends on sbrm_pkg for beat structs, status codes and register indexes.

// One processor write per beat: unless it comes too soon after the last reset,
// bit 7 of the data resets the serial register, otherwise bit 0 shifts in and
// the fifth bit loads the register chosen by reg_select. A beat is taken into
// an input register, updates the mapper state and lands in a result register
// once that is free, so each write gives exactly one result beat; a new write
// is accepted every cycle unless the result register is held, which is the only
// stall: a held result register holds the input register and raises wr_stall.
// Configuration writes must be made while no write is in flight.
module serial_bank_register_mapper (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	output logic                wr_stall,
	input  sbrm_pkg::wr_beat_t  wr_beat,
	output logic                res_valid,
	input  logic                res_stall,
	output sbrm_pkg::res_beat_t res_beat,
	input  logic                cfg_en,
	input  logic [1:0]          cfg_index,
	input  logic [1:0]          cfg_data
);

	// Configuration
	logic [1:0] wram_size_q;
	logic       ignore_wram_en_q;
	logic       no_mirror_q;

	// Mapper state
	logic [4:0]                   shift_bits_q;
	logic [2:0]                   shift_count_q;
	logic [4:0]                   control_q;
	logic [4:0]                   chr_low_q;
	logic [4:0]                   chr_high_q;
	logic [4:0]                   prg_q;
	logic [sbrm_pkg::STAMP_W-1:0] last_reset_q;

	// Input stage
	logic               valid_s1;
	sbrm_pkg::wr_beat_t beat_s1;

	// Result stage
	logic                valid_s2;
	sbrm_pkg::res_beat_t beat_s2;

	logic advance;
	logic take_in;
	logic too_soon;
	logic [sbrm_pkg::STAMP_W-1:0] stamp_diff;
	logic [4:0] shift_bits_d;
	logic [2:0] shift_count_d;
	logic [4:0] control_d;
	logic [4:0] chr_low_d;
	logic [4:0] chr_high_d;
	logic [4:0] prg_d;
	logic [1:0] status_d;
	logic [4:0] collected;
	logic       offs;
	logic [3:0] bank;
	sbrm_pkg::res_beat_t res_d;

	// Move the input stage on whenever the result register is free or drains
	assign advance  = !valid_s2 || !res_stall;
	assign wr_stall = valid_s1 && !advance;
	assign take_in  = wr_valid && !wr_stall;

	assign res_valid = valid_s2;
	assign res_beat  = beat_s2;

	// Hold configuration registers; ignore indexes past the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wram_size_q      <= sbrm_pkg::WRAM_SIZE_RST;
			ignore_wram_en_q <= 1'b0;
			no_mirror_q      <= 1'b0;
		end else if (cfg_en) begin
			unique case (cfg_index)
				sbrm_pkg::CFG_WRAM_SIZE:      wram_size_q      <= cfg_data;
				sbrm_pkg::CFG_IGNORE_WRAM_EN: ignore_wram_en_q <= cfg_data[0];
				sbrm_pkg::CFG_NO_MIRROR:      no_mirror_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Capture the write beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance || !valid_s1) begin
			valid_s1 <= take_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			beat_s1 <= wr_beat;
		end
	end

	// Drop writes that come too soon after the last reset write
	assign stamp_diff = beat_s1.cycle_stamp - last_reset_q;
	assign too_soon   = (beat_s1.cycle_stamp < last_reset_q) ||
		(stamp_diff[sbrm_pkg::STAMP_W-1:1] == '0);

	assign collected = shift_bits_q | ({4'd0, beat_s1.write_data[0]} << shift_count_q);

	// Work out the next mapper state for the beat in the input stage
	always_comb begin
		shift_bits_d  = shift_bits_q;
		shift_count_d = shift_count_q;
		control_d     = control_q;
		chr_low_d     = chr_low_q;
		chr_high_d    = chr_high_q;
		prg_d         = prg_q;
		priority if (too_soon) begin
			status_d = sbrm_pkg::ST_TOO_SOON;
		end else if (beat_s1.write_data[7]) begin
			status_d      = sbrm_pkg::ST_RESET;
			control_d     = control_q | 5'b01100;
			shift_bits_d  = '0;
			shift_count_d = '0;
		end else if (shift_count_q != sbrm_pkg::SHIFT_LAST) begin
			status_d      = sbrm_pkg::ST_SHIFTED;
			shift_bits_d  = collected;
			shift_count_d = shift_count_q + 3'd1;
		end else begin
			status_d      = sbrm_pkg::ST_LOADED;
			shift_bits_d  = '0;
			shift_count_d = '0;
			unique case (beat_s1.reg_select)
				sbrm_pkg::SEL_CONTROL:  control_d  = collected;
				sbrm_pkg::SEL_CHR_LOW:  chr_low_d  = collected;
				sbrm_pkg::SEL_CHR_HIGH: chr_high_d = collected;
				sbrm_pkg::SEL_PRG:      prg_d      = collected;
				default:                prg_d      = collected;
			endcase
		end
	end

	// Resolve banks and modes from the updated state
	assign offs = chr_low_d[4];
	assign bank = prg_d[3:0];

	always_comb begin
		res_d              = '0;
		res_d.write_status = status_d;
		unique case (control_d[3:2])
			sbrm_pkg::PRG_FIX_HIGH: begin
				res_d.prg_bank_low  = {offs, bank};
				res_d.prg_bank_high = {offs, 4'hF};
			end
			sbrm_pkg::PRG_FIX_LOW: begin
				res_d.prg_bank_low  = {offs, 4'h0};
				res_d.prg_bank_high = {offs, bank};
			end
			default: begin
				res_d.prg_bank_low  = {offs, bank[3:1], 1'b0};
				res_d.prg_bank_high = {offs, bank[3:1], 1'b1};
			end
		endcase
		if (control_d[4]) begin
			res_d.chr_bank_low  = chr_low_d;
			res_d.chr_bank_high = chr_high_d;
		end else begin
			res_d.chr_bank_low  = {chr_low_d[4:1], 1'b0};
			res_d.chr_bank_high = {chr_low_d[4:1], 1'b1};
		end
		res_d.mirroring     = no_mirror_q ? 2'd0 : control_d[1:0];
		res_d.mirror_driven = !no_mirror_q;
		res_d.wram_enabled  = (wram_size_q != sbrm_pkg::WRAM_NONE) &&
			(!prg_d[4] || ignore_wram_en_q);
		priority if (wram_size_q == sbrm_pkg::WRAM_32K) begin
			res_d.wram_bank = chr_low_d[3:2];
		end else if (wram_size_q == sbrm_pkg::WRAM_16K) begin
			res_d.wram_bank = {1'b0, chr_low_d[3]};
		end else begin
			res_d.wram_bank = 2'd0;
		end
	end

	// Advance mapper state as each write leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_bits_q  <= '0;
			shift_count_q <= '0;
			control_q     <= sbrm_pkg::CONTROL_RST;
			chr_low_q     <= '0;
			chr_high_q    <= '0;
			prg_q         <= '0;
			last_reset_q  <= '0;
		end else if (valid_s1 && advance) begin
			shift_bits_q  <= shift_bits_d;
			shift_count_q <= shift_count_d;
			control_q     <= control_d;
			chr_low_q     <= chr_low_d;
			chr_high_q    <= chr_high_d;
			prg_q         <= prg_d;
			if (!too_soon && beat_s1.write_data[7]) begin
				last_reset_q <= beat_s1.cycle_stamp;
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			beat_s2 <= res_d;
		end
	end

endmodule

>>> verif/sbrm_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the serial bank register mapper: watches the write, result and config ports.
// Keeps its own copy of the mapper state and compares every result beat; needs sbrm_pkg.
module sbrm_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_valid,
	input  logic                wr_stall,
	input  sbrm_pkg::wr_beat_t  wr_beat,
	input  logic                res_valid,
	input  logic                res_stall,
	input  sbrm_pkg::res_beat_t res_beat,
	input  logic                cfg_en,
	input  logic [1:0]          cfg_index,
	input  logic [1:0]          cfg_data,
	output int                  fail_count,
	output int                  pending_count,
	output int                  checked_count,
	output int                  load_count,
	output int                  ignored_count
);
	import sbrm_pkg::*;

	// Shadow configuration
	logic [1:0] wram_size_q;
	logic       ignore_wen_q;
	logic       no_mirror_q;

	// Shadow mapper state
	logic [4:0]         shift_q;
	logic [2:0]         shift_cnt_q;
	logic [4:0]         control_q;
	logic [4:0]         chr_low_q;
	logic [4:0]         chr_high_q;
	logic [4:0]         prg_q;
	logic [STAMP_W-1:0] reset_stamp_q;

	// Bank views still owed by the block, oldest first
	res_beat_t bank_views[$];

	// Resolve the current registers into the bank numbers the block reports
	function automatic res_beat_t mapper_view(input logic [1:0] status);
		res_beat_t v;
		logic      outer;
		logic [3:0] bank;
		begin
			outer = chr_low_q[4];
			bank  = prg_q[3:0];
			v = '0;
			v.write_status = status;
			case (control_q[3:2])
				PRG_FIX_HIGH: begin
					v.prg_bank_low  = {outer, bank};
					v.prg_bank_high = {outer, 4'hF};
				end
				PRG_FIX_LOW: begin
					v.prg_bank_low  = {outer, 4'h0};
					v.prg_bank_high = {outer, bank};
				end
				default: begin
					// 32KB pair: bank bit 0 is dropped
					v.prg_bank_low  = {outer, bank[3:1], 1'b0};
					v.prg_bank_high = {outer, bank[3:1], 1'b1};
				end
			endcase
			if (control_q[4]) begin
				v.chr_bank_low  = chr_low_q;
				v.chr_bank_high = chr_high_q;
			end else begin
				v.chr_bank_low  = {chr_low_q[4:1], 1'b0};
				v.chr_bank_high = {chr_low_q[4:1], 1'b1};
			end
			v.mirroring     = no_mirror_q ? 2'd0 : control_q[1:0];
			v.mirror_driven = !no_mirror_q;
			v.wram_enabled  = (wram_size_q != WRAM_NONE) && (!prg_q[4] || ignore_wen_q);
			case (wram_size_q)
				WRAM_32K: v.wram_bank = chr_low_q[3:2];
				WRAM_16K: v.wram_bank = {1'b0, chr_low_q[3]};
				default:  v.wram_bank = 2'd0;
			endcase
			return v;
		end
	endfunction

	// Apply one processor write to the shadow state, return its status
	function automatic logic [1:0] step_mapper(input wr_beat_t b);
		logic [4:0] loaded;
		begin
			if (b.cycle_stamp < reset_stamp_q || (b.cycle_stamp - reset_stamp_q) < 2)
				return ST_TOO_SOON;
			if (b.write_data[7]) begin
				// force fixed-upper program mode, clear the serial register
				control_q     = control_q | 5'b01100;
				shift_q       = '0;
				shift_cnt_q   = '0;
				reset_stamp_q = b.cycle_stamp;
				return ST_RESET;
			end
			shift_q[shift_cnt_q] = b.write_data[0];
			if (shift_cnt_q != SHIFT_LAST) begin
				shift_cnt_q = shift_cnt_q + 3'd1;
				return ST_SHIFTED;
			end
			loaded      = shift_q;
			shift_q     = '0;
			shift_cnt_q = '0;
			case (b.reg_select)
				SEL_CONTROL:  control_q  = loaded;
				SEL_CHR_LOW:  chr_low_q  = loaded;
				SEL_CHR_HIGH: chr_high_q = loaded;
				default:      prg_q      = loaded;
			endcase
			return ST_LOADED;
		end
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		res_beat_t  want;
		logic [1:0] status;
		if (!arst_n) begin
			wram_size_q   = WRAM_SIZE_RST;
			ignore_wen_q  = 1'b0;
			no_mirror_q   = 1'b0;
			shift_q       = '0;
			shift_cnt_q   = '0;
			control_q     = CONTROL_RST;
			chr_low_q     = '0;
			chr_high_q    = '0;
			prg_q         = '0;
			reset_stamp_q = '0;
			bank_views.delete();
			fail_count    = 0;
			pending_count = 0;
			checked_count = 0;
			load_count    = 0;
			ignored_count = 0;
		end else begin
			// Track register writes
			if (cfg_en) begin
				case (cfg_index)
					CFG_WRAM_SIZE:      wram_size_q  = cfg_data;
					CFG_IGNORE_WRAM_EN: ignore_wen_q = cfg_data[0];
					CFG_NO_MIRROR:      no_mirror_q  = cfg_data[0];
					default: ;
				endcase
			end
			// Predict on every accepted write beat
			if (wr_valid && !wr_stall) begin
				status = step_mapper(wr_beat);
				bank_views.push_back(mapper_view(status));
				if (status == ST_LOADED)
					load_count++;
				if (status == ST_TOO_SOON)
					ignored_count++;
			end
			// Compare every accepted result beat against the oldest prediction
			if (res_valid && !res_stall) begin
				if (bank_views.size() == 0) begin
					$error("result beat arrived with no write awaiting it");
					fail_count++;
				end else begin
					want = bank_views.pop_front();
					check_field("write_status", want.write_status, res_beat.write_status);
					check_field("prg_bank_low", want.prg_bank_low, res_beat.prg_bank_low);
					check_field("prg_bank_high", want.prg_bank_high, res_beat.prg_bank_high);
					check_field("chr_bank_low", want.chr_bank_low, res_beat.chr_bank_low);
					check_field("chr_bank_high", want.chr_bank_high, res_beat.chr_bank_high);
					check_field("mirroring", want.mirroring, res_beat.mirroring);
					check_field("mirror_driven", want.mirror_driven, res_beat.mirror_driven);
					check_field("wram_enabled", want.wram_enabled, res_beat.wram_enabled);
					check_field("wram_bank", want.wram_bank, res_beat.wram_bank);
					checked_count++;
				end
			end
			pending_count = bank_views.size();
		end
	end

endmodule

>>> verif/tb_serial_bank_register_mapper.sv
`timescale 1ns / 100ps
// Top of the mapper testbench: clock, reset, write and config stimulus, result-side stalls.
// Depends on sbrm_pkg, the mapper RTL and sbrm_checker, which does all the comparing.
module tb_serial_bank_register_mapper;
	import sbrm_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 200;
	localparam int HOLD_CYCLES = 48;

	// Result-side stall patterns
	localparam int RX_OPEN     = 0;
	localparam int RX_LIGHT    = 1;
	localparam int RX_HEAVY    = 2;
	localparam int RX_PERIODIC = 3;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       wr_valid  = 1'b0;
	logic       wr_stall;
	wr_beat_t   wr_beat   = '0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	res_beat_t  res_beat;
	logic       cfg_en    = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [1:0] cfg_data  = '0;

	int fail_count;
	int pending_count;
	int checked_count;
	int load_count;
	int ignored_count;

	int cycle_count  = 0;
	int beats_sent   = 0;
	int settings_run = 1;

	// Sender state
	logic [STAMP_W-1:0] stamp_now  = '0;
	bit                 offering   = 1'b0;
	int                 burst_left = 0;

	// Receiver state
	int hold_asked  = 0;
	int hold_served = 0;
	int hold_left   = 0;
	int rx_mode     = RX_OPEN;
	int rx_tick     = 0;

	always #5 clk = ~clk;

	serial_bank_register_mapper dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_valid  (wr_valid),
		.wr_stall  (wr_stall),
		.wr_beat   (wr_beat),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_beat  (res_beat),
		.cfg_en    (cfg_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	sbrm_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_valid      (wr_valid),
		.wr_stall      (wr_stall),
		.wr_beat       (wr_beat),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.res_beat      (res_beat),
		.cfg_en        (cfg_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count),
		.load_count    (load_count),
		.ignored_count (ignored_count)
	);

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycle_count, pending_count);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Result side: long hold when asked, otherwise a stall pattern that changes now and then
	always @(posedge clk) begin
		rx_tick++;
		if (rx_tick % 97 == 0)
			rx_mode = $urandom_range(RX_OPEN, RX_PERIODIC);
		if (hold_left == 0 && hold_served != hold_asked) begin
			hold_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			case (rx_mode)
				RX_OPEN:  res_stall <= 1'b0;
				RX_LIGHT: res_stall <= ($urandom_range(0, 3) == 0);
				RX_HEAVY: res_stall <= ($urandom_range(0, 9) < 6);
				default:  res_stall <= (rx_tick % 8 == 5);
			endcase
		end
	end

	// Offer one write beat and hold it until accepted; bursts with random gaps
	task automatic send_write(input logic [1:0] sel, input logic [7:0] data,
			input logic [STAMP_W-1:0] stamp);
		wr_beat_t b;
		b.reg_select  = sel;
		b.write_data  = data;
		b.cycle_stamp = stamp;
		if (burst_left == 0) begin
			if (offering) begin
				wr_valid <= 1'b0;
				offering = 1'b0;
			end
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? 120 : $urandom_range(1, 20);
		end
		wr_valid <= 1'b1;
		wr_beat  <= b;
		offering = 1'b1;
		do @(posedge clk); while (wr_stall);
		burst_left--;
		beats_sent++;
	endtask

	// Advance the processor cycle stamp by a random step between writes
	function automatic logic [STAMP_W-1:0] advance_stamp();
		stamp_now = stamp_now + $urandom_range(0, 3);
		return stamp_now;
	endfunction

	// Five serial writes that load value into the register picked by sel
	task automatic serial_load(input logic [1:0] sel, input logic [4:0] value);
		for (int i = 0; i < 5; i++)
			send_write((i == 4) ? sel : 2'($urandom), {1'b0, 6'($urandom), value[i]},
				advance_stamp());
	endtask

	task automatic reset_write();
		send_write(2'($urandom), 8'h80 | 8'($urandom), advance_stamp());
	endtask

	// Drop valid and wait until every result is back
	task automatic quiesce();
		if (offering) begin
			wr_valid <= 1'b0;
			offering = 1'b0;
		end
		burst_left = 0;
		@(posedge clk);
		wait (pending_count == 0);
		repeat (3) @(posedge clk);
	endtask

	// Write all three registers on consecutive edges; block must be idle
	task automatic set_config(input logic [1:0] size, input logic ign, input logic nomir);
		cfg_en    <= 1'b1;
		cfg_index <= CFG_WRAM_SIZE;
		cfg_data  <= size;
		@(posedge clk);
		cfg_index <= CFG_IGNORE_WRAM_EN;
		cfg_data  <= {1'($urandom), ign};
		@(posedge clk);
		cfg_index <= CFG_NO_MIRROR;
		cfg_data  <= {1'($urandom), nomir};
		@(posedge clk);
		cfg_en <= 1'b0;
		settings_run++;
	endtask

	// Mostly well-formed loads with random content, plus resets and noise
	task automatic random_traffic(input int count);
		int done;
		int pick;
		done = 0;
		while (done < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				if ($urandom_range(0, 3) == 0) begin
					reset_write();
					done++;
				end
				serial_load(2'($urandom), 5'($urandom));
				done += 5;
			end else if (pick < 70) begin
				reset_write();
				done++;
			end else if (pick < 80) begin
				// lone bit, leaves a sequence half done
				send_write(2'($urandom), {1'b0, 7'($urandom)}, advance_stamp());
				done++;
			end else if (pick < 90) begin
				// stale stamp, may land before the last reset
				send_write(2'($urandom), 8'($urandom), stamp_now - $urandom_range(0, 4));
				done++;
			end else begin
				// far-off stamp on a non-reset write
				send_write(2'($urandom), {1'b0, 7'($urandom)},
					{8'($urandom), 32'($urandom)});
				done++;
			end
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Early writes right after reset are ignored, including a reset
		send_write(SEL_CONTROL, 8'h01, 40'd0);
		send_write(SEL_PRG, 8'hFF, 40'd1);
		// All-ones stamp on a shifted bit, then a reset that clears it
		send_write(SEL_CHR_HIGH, 8'h00, {STAMP_W{1'b1}});
		send_write(SEL_CONTROL, 8'h80, 40'd2);
		// A write stamped right after the reset is still too soon
		send_write(SEL_CHR_LOW, 8'h7F, 40'd3);
		stamp_now = 40'd4;
		// Load every register once
		serial_load(SEL_CONTROL, 5'h13);
		serial_load(SEL_CHR_LOW, 5'h1D);
		serial_load(SEL_CHR_HIGH, 5'h0A);
		serial_load(SEL_PRG, 5'h1F);
		quiesce();

		// Random phases under a range of settings, extremes first
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       set_config(WRAM_NONE, 1'b0, 1'b0);
				1:       set_config(WRAM_32K, 1'b1, 1'b1);
				2:       set_config(WRAM_16K, 1'b0, 1'b1);
				3:       set_config(WRAM_SIZE_RST, 1'b1, 1'b0);
				default: set_config(2'($urandom), 1'($urandom), 1'($urandom));
			endcase
			random_traffic(PHASE_ITEMS / 2);
			// result side holds off while writes keep coming
			hold_asked++;
			random_traffic(PHASE_ITEMS / 4);
			// sender pause until everything has drained
			quiesce();
			random_traffic(PHASE_ITEMS / 4);
			quiesce();
		end

		repeat (8) @(posedge clk);
		$display("Sent %0d write beats over %0d register settings; %0d results compared.",
			beats_sent, settings_run, checked_count);
		$display("%0d writes loaded a bank register, %0d were dropped as too early.",
			load_count, ignored_count);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
